>>> rtl/tick_driven_uart_8n2_unit_defines.svh
//------------------------------------------------------------------------------
// Tick-driven UART 8N2 - assertion macros
// Shared property wrappers for the checker.
//------------------------------------------------------------------------------
`ifndef TICK_DRIVEN_UART_8N2_UNIT_DEFINES_SVH
`define TICK_DRIVEN_UART_8N2_UNIT_DEFINES_SVH

// checked outside reset only
`define TDU8_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define TDU8_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> rtl/tdu8_pkg.sv
//------------------------------------------------------------------------------
// Tick-driven UART 8N2 - package
// Word kinds, frame counter codes and the result word layout.
//------------------------------------------------------------------------------
package tdu8_pkg;

   typedef enum logic [1:0] {
      KIND_TICK = 2'd0,
      KIND_EDGE = 2'd1,
      KIND_SEND = 2'd2,
      KIND_READ = 2'd3
   } kind_type;

   localparam logic [3:0] CNT_START = 4'd0;
   localparam logic [3:0] CNT_DATA_LAST = 4'd8;
   localparam logic [3:0] CNT_FRAME_LAST = 4'd10;
   localparam logic [3:0] CNT_IDLE = 4'd11;

   localparam int unsigned REQ_DATA_W = 16;
   localparam int unsigned RSP_DATA_W = 16;

   // result word, lowest bit last
   typedef struct packed {
      logic [1:0] pad;
      logic       frame_error;
      logic       tx_complete;
      logic       rx_complete;
      logic [7:0] rx_byte;
      logic       accepted;
      logic       busy_res;
      logic       tx_line;
   } rsp_type;

endpackage

>>> rtl/tick_driven_uart_8n2_unit.sv
//------------------------------------------------------------------------------
// Tick-driven UART 8N2 unit
// One start bit, eight data bits LSB first, two stop bits, one sample a bit.
//------------------------------------------------------------------------------
// Usage:
//   req channel: one word per event. tuser carries the kind (bit tick, rx
//   line edge, send byte, read byte); tdata carries the rx level and the
//   byte to send. A tick samples rx and advances both the receiver and the
//   transmitter by one bit period.
//   rsp channel: one word per request word with the tx line level, busy,
//   accepted flag, read byte and the rx/tx/frame-error status.
//   The response is valid in the cycle after accept; one word per cycle
//   while rsp_tready is high. The state update is a few-bit step done in
//   the accept cycle, so the response register is the only stage.
//   While the response sits unread and rsp_tready is low, req_tready drops;
//   it is high whenever the response register is empty or being drained.
//   Reset puts both the receiver and the transmitter in idle, the tx line
//   high, tx complete set and the response register empty.
//------------------------------------------------------------------------------
module tick_driven_uart_8n2_unit
   import tdu8_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // rx_level, send_byte[8:1], zero pad
   input  logic [1:0]            req_tuser,  // kind
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata   // tx_line, busy_res, accepted,
                                             // rx_byte[10:3], rx_complete,
                                             // tx_complete, frame_error, pad
);

   logic [3:0] rx_cnt_ff, rx_cnt_in;
   logic [3:0] tx_cnt_ff, tx_cnt_in;
   logic [7:0] rx_shift_ff, rx_shift_in;
   logic [7:0] tx_shift_ff, tx_shift_in;
   logic       rx_done_ff, rx_done_in;
   logic       tx_done_ff, tx_done_in;
   logic       frame_bad_ff, frame_bad_in;
   logic       tx_level_ff, tx_level_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff, rsp_in;

   logic       req_fire;
   kind_type   kind;
   logic       level;
   logic [7:0] byte_in;
   logic [2:0] rx_idx;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;
   assign kind       = kind_type'(req_tuser);
   assign level      = req_tdata[0];
   assign byte_in    = req_tdata[8:1];
   assign rx_idx     = 3'(rx_cnt_ff - 4'd1);

   always_comb begin
      rx_cnt_in    = rx_cnt_ff;
      tx_cnt_in    = tx_cnt_ff;
      rx_shift_in  = rx_shift_ff;
      tx_shift_in  = tx_shift_ff;
      rx_done_in   = rx_done_ff;
      tx_done_in   = tx_done_ff;
      frame_bad_in = frame_bad_ff;
      tx_level_in  = tx_level_ff;
      rsp_in       = '0;

      unique case (kind)
         KIND_TICK: begin
            // receiver
            if (rx_cnt_ff == CNT_START) begin
               if (level) begin
                  rx_cnt_in = CNT_IDLE;
               end else begin
                  rx_done_in  = 1'b0;
                  rx_shift_in = '0;
                  rx_cnt_in   = rx_cnt_ff + 4'd1;
               end
            end else if (rx_cnt_ff <= CNT_DATA_LAST) begin
               rx_shift_in[rx_idx] = rx_shift_ff[rx_idx] | level;
               rx_cnt_in           = rx_cnt_ff + 4'd1;
            end else if (rx_cnt_ff <= CNT_FRAME_LAST) begin
               if (!level) begin
                  frame_bad_in = 1'b1;
                  rx_done_in   = 1'b0;
                  rx_cnt_in    = CNT_IDLE;
               end else begin
                  if (rx_cnt_ff == CNT_FRAME_LAST) begin
                     rx_done_in   = 1'b1;
                     frame_bad_in = 1'b0;
                  end
                  rx_cnt_in = rx_cnt_ff + 4'd1;
               end
            end
            // transmitter
            if (tx_cnt_ff == CNT_START) begin
               tx_level_in = 1'b0;
               tx_cnt_in   = tx_cnt_ff + 4'd1;
            end else if (tx_cnt_ff <= CNT_DATA_LAST) begin
               tx_level_in = tx_shift_ff[0];
               tx_shift_in = tx_shift_ff >> 1;
               tx_cnt_in   = tx_cnt_ff + 4'd1;
            end else if (tx_cnt_ff <= CNT_FRAME_LAST) begin
               tx_level_in = 1'b1;
               if (tx_cnt_ff == CNT_FRAME_LAST) begin
                  tx_done_in = 1'b1;
               end
               tx_cnt_in = tx_cnt_ff + 4'd1;
            end
            rsp_in.busy_res = (rx_cnt_in <= CNT_FRAME_LAST) ||
                              (tx_cnt_in <= CNT_FRAME_LAST);
         end
         KIND_EDGE: begin
            // low line: start bit already seen, go straight to data
            if (!level) begin
               rx_done_in      = 1'b0;
               rx_shift_in     = '0;
               rx_cnt_in       = CNT_START + 4'd1;
               rsp_in.busy_res = 1'b1;
            end
         end
         KIND_SEND: begin
            if (tx_done_ff) begin
               tx_done_in      = 1'b0;
               tx_shift_in     = byte_in;
               tx_cnt_in       = CNT_START;
               rsp_in.accepted = 1'b1;
            end
         end
         KIND_READ: begin
            if (!frame_bad_ff) begin
               rx_done_in     = 1'b0;
               rsp_in.rx_byte = rx_shift_ff;
            end
         end
         default: begin
         end
      endcase

      rsp_in.tx_line     = tx_level_in;
      rsp_in.rx_complete = rx_done_in;
      rsp_in.tx_complete = tx_done_in;
      rsp_in.frame_error = frame_bad_in;
   end

   assign rsp_valid_in = req_fire || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_cnt_ff    <= CNT_IDLE;
         tx_cnt_ff    <= CNT_IDLE;
         rx_shift_ff  <= '0;
         tx_shift_ff  <= '0;
         rx_done_ff   <= 1'b0;
         tx_done_ff   <= 1'b1;
         frame_bad_ff <= 1'b0;
         tx_level_ff  <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_fire) begin
            rx_cnt_ff    <= rx_cnt_in;
            tx_cnt_ff    <= tx_cnt_in;
            rx_shift_ff  <= rx_shift_in;
            tx_shift_ff  <= tx_shift_in;
            rx_done_ff   <= rx_done_in;
            tx_done_ff   <= tx_done_in;
            frame_bad_ff <= frame_bad_in;
            tx_level_ff  <= tx_level_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

endmodule

>>> rtl/tdu8_checker.sv
//------------------------------------------------------------------------------
// Tick-driven UART 8N2 - port checker
// Watches the top-level ports; bound into the unit below.
//------------------------------------------------------------------------------
`include "tick_driven_uart_8n2_unit_defines.svh"

module tdu8_checker
   import tdu8_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [1:0]            req_tuser,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   `TDU8_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_tvalid, "rsp valid after reset")

   `TDU8_ASSERT(a_stall_hold,
                rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata),
                "stalled rsp word changed")

   `TDU8_ASSERT(a_word_out, req_tvalid && req_tready |=> rsp_tvalid,
                "accepted req word gave no rsp word")

   `TDU8_ASSERT(a_accept_kind,
                req_tvalid && req_tready && (req_tuser != KIND_SEND) |=> !rsp_tdata[2],
                "accepted flag on a non-send word")

   `TDU8_ASSERT(a_accept_busy, rsp_tvalid && rsp_tdata[2] |-> !rsp_tdata[12],
                "tx complete set with a byte just taken")

endmodule

bind tick_driven_uart_8n2_unit tdu8_checker u_tdu8_checker (.*);
